### src/stw_pkg.sv
// ----------------------------------------------------------------------------
// stw_pkg
// Shared constants and types of the swing time warp pipeline.
// ----------------------------------------------------------------------------
package stw_pkg;

  localparam int FRAC_BITS = 16;
  localparam logic [16:0] ONE_Q = 17'd65536;
  localparam logic [15:0] STRAIGHT_Q16 = 16'd32768;
  localparam logic [15:0] MAX_Q16 = 16'd49152;

  localparam int DIV_STAGES = 17;
  localparam int DVD_W = 40;
  localparam int DVS_W = 23;

  localparam logic [1:0] OP_FWD = 2'd0;
  localparam logic [1:0] OP_INV = 2'd1;
  localparam logic [1:0] OP_ENV = 2'd2;

  localparam logic CFG_CELL_COUNT = 1'b0;
  localparam logic CFG_SWING_AMOUNT = 1'b1;

  // settled configuration, shared by both lanes
  typedef struct packed {
    logic [6:0]  count;
    logic [15:0] amount;
    logic        on;
  } stw_cfg_t;

  // item data that rides beside the lanes
  typedef struct packed {
    logic [1:0]        op;
    logic [16:0]       x;
    logic [16:0]       y;
    logic signed [1:0] whole;
    logic [15:0]       frac;
    logic              pass_a;
    logic              pass_b;
  } stw_side_t;

endpackage

### src/swing_time_warp.sv
// ----------------------------------------------------------------------------
// swing_time_warp
// Swing warp of Q16 pattern positions: forward, inverse and envelope point.
//
//   channel  dir  handshake         payload
//   s_*      in   tvalid/tready     operation, position, offset
//   m_*      out  tvalid/tready     warped_position, warped_offset
//   cfg_*    in   cfg_valid/ready   cfg_index, cfg_data
//
// One transfer per cycle sustained while m_tready stays high; stages are
// input register, two prep stages, 17 divider stages, output register.
// Every stage holds its own valid bit and fills bubbles under stall.
// rst clears valid bits and loads the config reset values.
// ----------------------------------------------------------------------------
module swing_time_warp (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [39:0] s_tdata,   // operation[1:0], position[18:2], offset[35:19]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [39:0] m_tdata,   // warped_position[16:0], warped_offset[33:17]
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        cfg_index,
  input  logic [15:0] cfg_data
);

  localparam int NST = 3 + stw_pkg::DIV_STAGES + 1;
  localparam int DIV0 = 3;
  localparam int OUT = NST - 1;

  logic [6:0]  cell_count;
  logic [15:0] swing_amount;
  logic [15:0] amt_cl;
  stw_pkg::stw_cfg_t cfg;

  logic [NST-1:0] v;
  logic [NST-1:0] en;
  stw_pkg::stw_side_t side [NST-1];
  stw_pkg::stw_side_t side_in;
  stw_pkg::stw_side_t side_div;

  logic [17:0] diff;
  logic [39:0] dvd_a, dvd_b;
  logic [22:0] dvs_a, dvs_b;
  logic        pass_a, pass_b;
  logic [16:0] q_a, q_b;

  logic [16:0]        xa, fb;
  logic signed [19:0] src, yr;
  logic [16:0]        px, py;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cell_count   <= 7'd16;
      swing_amount <= 16'd32768;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        stw_pkg::CFG_CELL_COUNT:   cell_count   <= cfg_data[6:0];
        stw_pkg::CFG_SWING_AMOUNT: swing_amount <= cfg_data;
        default: ;
      endcase
    end
  end

  always_comb begin
    amt_cl = swing_amount;
    if (amt_cl < stw_pkg::STRAIGHT_Q16) amt_cl = stw_pkg::STRAIGHT_Q16;
    if (amt_cl > stw_pkg::MAX_Q16) amt_cl = stw_pkg::MAX_Q16;
    cfg.count  = cell_count;
    cfg.amount = amt_cl;
    cfg.on     = (cell_count >= 7'd2) && (amt_cl > stw_pkg::STRAIGHT_Q16);
  end

  always_comb begin
    en[OUT] = !v[OUT] || m_tready;
    for (int i = OUT - 1; i >= 0; i--) en[i] = !v[i] || en[i+1];
  end

  assign s_tready = en[0];
  assign m_tvalid = v[OUT];

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else begin
      if (en[0]) v[0] <= s_tvalid;
      for (int i = 1; i < NST; i++) begin
        if (en[i]) v[i] <= v[i-1];
      end
    end
  end

  always_comb begin
    diff          = {1'b0, s_tdata[18:2]} - {1'b0, s_tdata[35:19]};
    side_in.op    = s_tdata[1:0];
    side_in.x     = s_tdata[18:2];
    side_in.y     = s_tdata[35:19];
    side_in.whole = diff[17:16];
    side_in.frac  = diff[15:0];
    side_in.pass_a = 1'b1;
    side_in.pass_b = 1'b1;
  end

  always_comb begin
    side_div        = side[DIV0-1];
    side_div.pass_a = pass_a;
    side_div.pass_b = pass_b;
  end

  always_ff @(posedge clk) begin
    if (en[0]) side[0] <= side_in;
    for (int i = 1; i < NST - 1; i++) begin
      if (en[i]) side[i] <= (i == DIV0) ? side_div : side[i-1];
    end
  end

  stw_prep u_prep_a (
    .clk      (clk),
    .en       (en[2:1]),
    .inv      (side[0].op == stw_pkg::OP_INV),
    .u        (side[0].x),
    .cfg      (cfg),
    .dividend (dvd_a),
    .divisor  (dvs_a),
    .pass     (pass_a)
  );

  stw_prep u_prep_b (
    .clk      (clk),
    .en       (en[2:1]),
    .inv      (1'b0),
    .u        ({1'b0, side[0].frac}),
    .cfg      (cfg),
    .dividend (dvd_b),
    .divisor  (dvs_b),
    .pass     (pass_b)
  );

  stw_div u_div_a (
    .clk      (clk),
    .en       (en[OUT-1:DIV0]),
    .dividend (dvd_a),
    .divisor  (dvs_a),
    .quotient (q_a)
  );

  stw_div u_div_b (
    .clk      (clk),
    .en       (en[OUT-1:DIV0]),
    .dividend (dvd_b),
    .divisor  (dvs_b),
    .quotient (q_b)
  );

  always_comb begin
    xa  = side[OUT-1].pass_a ? side[OUT-1].x : q_a;
    fb  = side[OUT-1].pass_b ? {1'b0, side[OUT-1].frac} : q_b;
    src = {{2{side[OUT-1].whole[1]}}, side[OUT-1].whole, 16'd0} + 20'(fb);
    yr  = 20'(xa) - src;
    px  = side[OUT-1].x;
    py  = side[OUT-1].y;
    case (side[OUT-1].op)
      stw_pkg::OP_FWD, stw_pkg::OP_INV: px = xa;
      stw_pkg::OP_ENV: begin
        if (cfg.on) begin
          px = xa;
          if (yr < 20'sd0) py = 17'd0;
          else if (yr > 20'sd65536) py = stw_pkg::ONE_Q;
          else py = yr[16:0];
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (en[OUT]) m_tdata <= {6'd0, py, px};
  end

endmodule

### src/stw_prep.sv
// ----------------------------------------------------------------------------
// stw_prep
// Two-stage front end of one lane: pair index, in-pair remainder, bypass
// test, then dividend and divisor of the forward or inverse map.
// ----------------------------------------------------------------------------
module stw_prep (
  input  logic                       clk,
  input  logic [1:0]                 en,
  input  logic                       inv,
  input  logic [16:0]                u,
  input  stw_pkg::stw_cfg_t          cfg,
  output logic [stw_pkg::DVD_W-1:0]  dividend,
  output logic [stw_pkg::DVS_W-1:0]  divisor,
  output logic                       pass
);

  logic [23:0] prod_uc;
  logic [6:0]  k_c;
  logic [8:0]  pair_end;
  logic        pass_c;

  logic [6:0]  k;
  logic [16:0] rem;
  logic        inv1;
  logic        pass1;

  logic [16:0] b;
  logic        lo_f;
  logic [15:0] mf_op;
  logic [15:0] mf_k;
  logic [31:0] mf_prod;
  logic [32:0] num_f;
  logic        lo_i;
  logic [15:0] s;
  logic [22:0] sk;
  logic [22:0] sc;
  logic [18:0] tail_i;
  logic [24:0] num_i;
  logic [39:0] dvd_next;
  logic [22:0] dvs_next;

  always_comb begin
    prod_uc  = 24'(u) * 24'(cfg.count);
    k_c      = prod_uc[23:17];
    pair_end = {1'b0, k_c, 1'b0} + 9'd2;
    pass_c   = !cfg.on || (u == 17'd0) || (u >= stw_pkg::ONE_Q)
               || (pair_end > 9'(cfg.count));
  end

  always_ff @(posedge clk) begin
    if (en[0]) begin
      k     <= k_c;
      rem   <= prod_uc[16:0];
      inv1  <= inv;
      pass1 <= pass_c;
    end
  end

  always_comb begin
    b       = stw_pkg::ONE_Q - 17'(cfg.amount);
    // forward
    lo_f    = rem < stw_pkg::ONE_Q;
    mf_op   = lo_f ? rem[15:0] : 16'(rem - stw_pkg::ONE_Q);
    mf_k    = lo_f ? cfg.amount : b[15:0];
    mf_prod = 32'(mf_op) * 32'(mf_k);
    num_f   = 33'(mf_prod) + (lo_f ? 33'd0 : {1'b0, cfg.amount, 16'd0});
    // inverse
    lo_i    = 18'(rem) < {1'b0, cfg.amount, 1'b0};
    s       = lo_i ? cfg.amount : b[15:0];
    sk      = 23'(s) * 23'(k);
    sc      = 23'(s) * 23'(cfg.count);
    tail_i  = lo_i ? 19'(rem)
                   : 19'(rem) + {1'b0, b, 1'b0} - {2'b0, cfg.amount, 1'b0};
    num_i   = {sk[22:0], 2'b0} + 25'(tail_i);
    if (inv1) begin
      dvd_next = {num_i, 15'd0};
      dvs_next = sc;
    end else begin
      dvd_next = {1'b0, k, 32'd0} + 40'(num_f);
      dvs_next = {1'b0, cfg.count, 15'd0};
    end
  end

  always_ff @(posedge clk) begin
    if (en[1]) begin
      dividend <= dvd_next;
      divisor  <= dvs_next;
      pass     <= pass1;
    end
  end

endmodule

### src/stw_div.sv
// ----------------------------------------------------------------------------
// stw_div
// Pipelined restoring divider, one quotient bit per stage, 17-bit quotient.
// ----------------------------------------------------------------------------
module stw_div (
  input  logic                                clk,
  input  logic [stw_pkg::DIV_STAGES-1:0]      en,
  input  logic [stw_pkg::DVD_W-1:0]           dividend,
  input  logic [stw_pkg::DVS_W-1:0]           divisor,
  output logic [stw_pkg::DIV_STAGES-1:0]      quotient
);

  localparam int N = stw_pkg::DIV_STAGES;

  logic [stw_pkg::DVD_W-1:0] rem_r [N];
  logic [stw_pkg::DVS_W-1:0] dvs_r [N];
  logic [N-1:0]              quo_r [N];

  for (genvar j = 0; j < N; j++) begin : g_stage
    localparam int SH = N - 1 - j;
    logic [stw_pkg::DVD_W-1:0] rem_p;
    logic [stw_pkg::DVS_W-1:0] dvs_p;
    logic [N-1:0]              quo_p;
    logic [stw_pkg::DVD_W-1:0] d_sh;
    logic                      ge;

    if (j == 0) begin : g_first
      assign rem_p = dividend;
      assign dvs_p = divisor;
      assign quo_p = '0;
    end else begin : g_rest
      assign rem_p = rem_r[j-1];
      assign dvs_p = dvs_r[j-1];
      assign quo_p = quo_r[j-1];
    end

    assign d_sh = stw_pkg::DVD_W'(dvs_p) << SH;
    assign ge   = rem_p >= d_sh;

    always_ff @(posedge clk) begin
      if (en[j]) begin
        rem_r[j] <= ge ? rem_p - d_sh : rem_p;
        dvs_r[j] <= dvs_p;
        quo_r[j] <= {quo_p[N-2:0], ge};
      end
    end
  end

  assign quotient = quo_r[N-1];

endmodule

### verif/swing_time_warp_chk.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// swing_time_warp_chk
// Watches the input, output and register channels of swing_time_warp,
// predicts each warped position and offset, and compares them in order.
// ----------------------------------------------------------------------------
module swing_time_warp_chk (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  input  logic        s_tready,
  input  logic [39:0] s_tdata,
  input  logic        m_tvalid,
  input  logic        m_tready,
  input  logic [39:0] m_tdata,
  input  logic        cfg_valid,
  input  logic        cfg_ready,
  input  logic        cfg_index,
  input  logic [15:0] cfg_data,
  output int          fail_count,
  output int          pending
);

  localparam longint ONE = 64'd65536;

  longint cells;
  longint amount_reg;
  logic [33:0] warp_queue[$];

  function automatic longint eff_amount();
    longint a;
    a = amount_reg;
    if (a < stw_pkg::STRAIGHT_Q16) a = stw_pkg::STRAIGHT_Q16;
    if (a > stw_pkg::MAX_Q16) a = stw_pkg::MAX_Q16;
    if (a > ONE - 1) a = ONE - 1;
    return a;
  endfunction

  function automatic bit swing_active();
    return cells >= 2 && eff_amount() > stw_pkg::STRAIGHT_Q16;
  endfunction

  function automatic longint fwd_map(longint u);
    longint a, k, r, n;
    if (!swing_active() || u == 0 || u >= ONE) return u;
    a = eff_amount();
    k = (u * cells) / (2 * ONE);
    if (2 * (k + 1) > cells) return u;
    r = u * cells - k * 2 * ONE;
    if (r < ONE) n = r * a;
    else n = a * ONE + (r - ONE) * (ONE - a);
    return (2 * (k * ONE * ONE + n)) / (cells * ONE);
  endfunction

  function automatic longint inv_map(longint t);
    longint a, b, k, r, n, dv;
    if (!swing_active() || t == 0 || t >= ONE) return t;
    a = eff_amount();
    b = ONE - a;
    k = (t * cells) / (2 * ONE);
    if (2 * (k + 1) > cells) return t;
    r = t * cells - k * 2 * ONE;
    if (r < 2 * a) begin
      n = 4 * a * k + r;
      dv = 2 * a * cells;
    end else begin
      n = 4 * b * k + 2 * b + r - 2 * a;
      dv = 2 * b * cells;
    end
    return (ONE * n) / dv;
  endfunction

  function automatic logic [33:0] warp_item(logic [39:0] d);
    logic [1:0] op;
    longint x, y, px, py, dd, whole, src;
    op = d[1:0];
    x = d[18:2];
    y = d[35:19];
    px = x;
    py = y;
    if (op == stw_pkg::OP_FWD) begin
      px = fwd_map(x);
    end else if (op == stw_pkg::OP_INV) begin
      px = inv_map(x);
    end else if (op == stw_pkg::OP_ENV && swing_active()) begin
      px = fwd_map(x);
      dd = x - y;
      if (dd >= 0) whole = dd / ONE;
      else whole = -((-dd + ONE - 1) / ONE);
      src = whole * ONE + fwd_map(dd - whole * ONE);
      py = px - src;
      if (py < 0) py = 0;
      if (py > ONE) py = ONE;
    end
    return {py[16:0], px[16:0]};
  endfunction

  assign pending = warp_queue.size();

  always @(posedge clk) begin
    logic [33:0] want;
    if (rst) begin
      cells <= 16;
      amount_reg <= 32768;
      fail_count <= 0;
      warp_queue.delete();
    end else begin
      if (m_tvalid && m_tready) begin
        if (warp_queue.size() == 0) begin
          fail_count <= fail_count + 1;
          if (fail_count < 10) $display("unexpected transfer %h", m_tdata);
        end else begin
          want = warp_queue.pop_front();
          if (want != m_tdata[33:0] || m_tdata[39:34] != 0) begin
            fail_count <= fail_count + 1;
            if (fail_count < 10)
              $display("mismatch: pos exp %0d got %0d, ofs exp %0d got %0d",
                       want[16:0], m_tdata[16:0], want[33:17], m_tdata[33:17]);
          end
        end
      end
      if (s_tvalid && s_tready) warp_queue.push_back(warp_item(s_tdata));
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == stw_pkg::CFG_CELL_COUNT) cells = cfg_data[6:0];
        else amount_reg = cfg_data;
      end
    end
  end

endmodule

### verif/swing_time_warp_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// swing_time_warp_tb
// Drives directed and random warp requests through several register
// settings with bursty input, a stalling sink and one long hold-off.
// ----------------------------------------------------------------------------
module swing_time_warp_tb;

  localparam int WATCHDOG = 5000;

  logic        clk;
  logic        rst;
  logic        s_tvalid;
  logic        s_tready;
  logic [39:0] s_tdata;
  logic        m_tvalid;
  logic        m_tready;
  logic [39:0] m_tdata;
  logic        cfg_valid;
  logic        cfg_ready;
  logic        cfg_index;
  logic [15:0] cfg_data;
  int          fail_count;
  int          pending;
  int          idle_cycles;
  bit          hold_off;

  swing_time_warp u_dut (.*);

  swing_time_warp_chk u_chk (.*);

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  // sink: random stalls, plain stretches, and one long hold-off
  initial begin
    int mode;
    m_tready = 0;
    forever begin
      @(negedge clk);
      if (hold_off) m_tready <= 0;
      else begin
        mode = $urandom_range(0, 99);
        m_tready <= (mode < 60) || ($urandom_range(0, 3) == 0 && mode < 90) || mode >= 90;
        if (mode >= 90) repeat ($urandom_range(5, 40)) @(negedge clk);
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG) begin
      $display("swing_time_warp_tb: errors");
      $finish;
    end
  end

  task automatic write_reg(logic idx, logic [15:0] val);
    cfg_valid <= 1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 0;
  endtask

  task automatic send_warp(logic [1:0] op, logic [16:0] pos, logic [16:0] ofs);
    s_tvalid <= 1;
    s_tdata <= {4'd0, ofs, pos, op};
    do @(posedge clk); while (!s_tready);
    @(negedge clk);
  endtask

  task automatic gap();
    s_tvalid <= 0;
    repeat ($urandom_range(1, 8)) @(negedge clk);
  endtask

  task automatic drain();
    s_tvalid <= 0;
    while (pending != 0) @(negedge clk);
    repeat (30) @(negedge clk);
  endtask

  function automatic logic [16:0] rand_pos();
    int r;
    r = $urandom_range(0, 19);
    if (r == 0) return 17'd0;
    if (r == 1) return 17'd65536;
    if (r == 2) return 17'h1FFFF;
    if (r == 3) return 17'($urandom_range(65537, 131071));
    return 17'($urandom_range(1, 65535));
  endfunction

  initial begin
    logic [15:0] amounts[6] = '{16'd32768, 16'd49152, 16'd0, 16'd65535, 16'd40000, 16'd32769};
    logic [6:0]  counts[6]  = '{7'd16, 7'd2, 7'd0, 7'd127, 7'd7, 7'd64};
    logic [16:0] edges[5]   = '{17'd0, 17'd1, 17'd65535, 17'd65536, 17'h1FFFF};
    int burst;
    rst = 1;
    s_tvalid = 0;
    s_tdata = 0;
    cfg_valid = 0;
    cfg_index = stw_pkg::CFG_CELL_COUNT;
    cfg_data = 0;
    hold_off = 0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst = 0;

    // directed: edges of every field, all ops at reset settings
    foreach (edges[i]) begin
      send_warp(stw_pkg::OP_FWD, edges[i], edges[4 - i]);
      send_warp(stw_pkg::OP_INV, edges[i], edges[i]);
      send_warp(stw_pkg::OP_ENV, edges[i], edges[4 - i]);
    end
    send_warp(2'd3, 17'd30000, 17'd1234);
    send_warp(stw_pkg::OP_ENV, 17'd100, 17'd60000);
    send_warp(stw_pkg::OP_ENV, 17'd65000, 17'd20);
    drain();

    for (int ph = 0; ph < 6; ph++) begin
      write_reg(stw_pkg::CFG_CELL_COUNT, {9'd0, counts[ph]});
      write_reg(stw_pkg::CFG_SWING_AMOUNT, amounts[ph]);
      for (int n = 0; n < 180; ) begin
        burst = $urandom_range(1, 30);
        if (ph == 1 && n == 0) begin
          fork
            begin
              hold_off = 1;
              repeat (200) @(negedge clk);
              hold_off = 0;
            end
          join_none
        end
        for (int b = 0; b < burst; b++, n++)
          send_warp(2'($urandom_range(0, 3)), rand_pos(), rand_pos());
        if ($urandom_range(0, 2) != 0) gap();
      end
      drain();
    end

    if (fail_count == 0) $display("swing_time_warp_tb: clean");
    else $display("swing_time_warp_tb: errors");
    $finish;
  end

endmodule
